// ===== src/mvfl_pkg.sv =====
// shared types, constants and the crc step for the optical flow framer
// no dependencies; every other file of the block imports this package
package mvfl_pkg;

    // frame layout
    localparam logic [7:0]  START_BYTE     = 8'hFE;
    localparam logic [7:0]  PAYLOAD_LEN    = 8'd26;
    localparam logic [5:0]  POS_START      = 6'd0;
    localparam logic [5:0]  POS_LEN        = 6'd1;
    localparam logic [5:0]  POS_SEQ        = 6'd2;
    localparam logic [5:0]  POS_SYS        = 6'd3;
    localparam logic [5:0]  POS_COMP       = 6'd4;
    localparam logic [5:0]  POS_MSG        = 6'd5;
    localparam logic [5:0]  POS_FX_LO      = 6'd26;
    localparam logic [5:0]  POS_FX_HI      = 6'd27;
    localparam logic [5:0]  POS_FY_LO      = 6'd28;
    localparam logic [5:0]  POS_FY_HI      = 6'd29;
    localparam logic [5:0]  POS_SENSOR     = 6'd30;
    localparam logic [5:0]  POS_QUALITY    = 6'd31;
    localparam logic [5:0]  POS_CRC_LO     = 6'd32;
    localparam logic [5:0]  POS_CRC_HI     = 6'd33;
    localparam logic [5:0]  POS_LAST       = POS_CRC_HI;
    localparam logic [15:0] CRC_SEED       = 16'hFFFF;

    // status led counter
    localparam logic [3:0]  LED_ON_COUNT   = 4'd5;
    localparam logic [3:0]  LED_WRAP_COUNT = 4'd10;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_SYSTEM_ID     = 3'd0,
        CFG_COMPONENT_ID  = 3'd1,
        CFG_MESSAGE_ID    = 3'd2,
        CFG_CRC_EXTRA     = 3'd3,
        CFG_SENSOR_NUMBER = 3'd4
    } cfg_index_t;

    // register reset values
    localparam logic [7:0] SYSTEM_ID_RST     = 8'd1;
    localparam logic [7:0] COMPONENT_ID_RST  = 8'd84;
    localparam logic [7:0] MESSAGE_ID_RST    = 8'd100;
    localparam logic [7:0] CRC_EXTRA_RST     = 8'd175;
    localparam logic [7:0] SENSOR_NUMBER_RST = 8'd0;

    typedef struct packed {
        logic signed [15:0] flow_x;
        logic signed [15:0] flow_y;
        logic [7:0]         quality;
    } in_item_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last;
        logic       led_on;
    } out_item_t;

    typedef struct packed {
        logic [7:0] system_id;
        logic [7:0] component_id;
        logic [7:0] message_id;
        logic [7:0] crc_extra;
        logic [7:0] sensor_number;
    } cfg_regs_t;

    // one frame job as it waits between front and back
    typedef struct packed {
        in_item_t   fields;
        logic [7:0] seq;
        logic       led;
    } frame_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    // one byte step of crc-16/mcrf4xx (reflected 0x1021)
    function automatic logic [15:0] crc_fold(input logic [15:0] acc, input logic [7:0] b);
        logic [7:0] t;
        t = b ^ acc[7:0];
        t = t ^ {t[3:0], 4'b0000};
        return {8'h00, acc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
    endfunction

endpackage

// ===== src/mvfl_front.sv =====
// front end: takes flow items, stamps sequence count and led level
// depends on mvfl_pkg; feeds mvfl_queue
module mvfl_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  mvfl_pkg::in_item_t    in_item,
    input  mvfl_pkg::queue_stat_t q_stat,
    output logic                  push,
    output mvfl_pkg::frame_job_t  push_job
);
    import mvfl_pkg::*;

    logic [7:0] seq_reg, seq_next;
    logic [3:0] led_cnt_reg, led_cnt_next;
    logic       led_reg, led_next;
    logic [3:0] cnt_inc;

    assign in_ready = !q_stat.full;
    assign push     = in_valid && in_ready;

    // led counter and sequence update for the accepted item
    always_comb
    begin
        cnt_inc      = led_cnt_reg + 4'd1;
        seq_next     = seq_reg;
        led_cnt_next = led_cnt_reg;
        led_next     = led_reg;
        if (push)
        begin
            seq_next     = seq_reg + 8'd1;
            led_cnt_next = cnt_inc;
            if (cnt_inc == LED_ON_COUNT)
            begin
                led_next = 1'b1;
            end
            else if (cnt_inc >= LED_WRAP_COUNT)
            begin
                led_next     = 1'b0;
                led_cnt_next = 4'd0;
            end
        end
    end

    // job carries the pre-increment sequence and the updated led level
    always_comb
    begin
        push_job.fields = in_item;
        push_job.seq    = seq_reg;
        push_job.led    = led_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg     <= 8'd0;
            led_cnt_reg <= 4'd0;
            led_reg     <= 1'b0;
        end
        else
        begin
            seq_reg     <= seq_next;
            led_cnt_reg <= led_cnt_next;
            led_reg     <= led_next;
        end
    end

endmodule

// ===== src/mvfl_queue.sv =====
// short job queue between front and back ends
// depends on mvfl_pkg for the job and status types
module mvfl_queue #(
    parameter int DEPTH = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  mvfl_pkg::frame_job_t  push_job,
    input  logic                  pop,
    output mvfl_pkg::frame_job_t  head_job,
    output mvfl_pkg::queue_stat_t q_stat
);
    import mvfl_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_MAX = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(DEPTH);

    frame_job_t     store_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;

    assign head_job     = store_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == CNT_MAX);
    assign q_stat.empty = (count_reg == '0);

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_MAX) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_MAX) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // job storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== src/mvfl_back.sv =====
// back end: serializes one job into 34 frame bytes with running crc
// depends on mvfl_pkg; reads the head of mvfl_queue
module mvfl_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mvfl_pkg::frame_job_t  head_job,
    input  mvfl_pkg::queue_stat_t q_stat,
    input  mvfl_pkg::cfg_regs_t   cfg,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output mvfl_pkg::out_item_t   out_item
);
    import mvfl_pkg::*;

    logic [5:0]  pos_reg, pos_next;
    logic [15:0] crc_reg, crc_next;
    logic        valid_reg, valid_next;
    out_item_t   data_reg, data_next;
    logic        load;
    logic [7:0]  cur_byte;
    logic [15:0] crc_step;

    assign load      = (!valid_reg || out_ready) && !q_stat.empty;
    assign pop       = load && (pos_reg == POS_LAST);
    assign out_valid = valid_reg;
    assign out_item  = data_reg;

    // byte select by position
    always_comb
    begin
        case (pos_reg)
            POS_START:   cur_byte = START_BYTE;
            POS_LEN:     cur_byte = PAYLOAD_LEN;
            POS_SEQ:     cur_byte = head_job.seq;
            POS_SYS:     cur_byte = cfg.system_id;
            POS_COMP:    cur_byte = cfg.component_id;
            POS_MSG:     cur_byte = cfg.message_id;
            POS_FX_LO:   cur_byte = head_job.fields.flow_x[7:0];
            POS_FX_HI:   cur_byte = head_job.fields.flow_x[15:8];
            POS_FY_LO:   cur_byte = head_job.fields.flow_y[7:0];
            POS_FY_HI:   cur_byte = head_job.fields.flow_y[15:8];
            POS_SENSOR:  cur_byte = cfg.sensor_number;
            POS_QUALITY: cur_byte = head_job.fields.quality;
            POS_CRC_LO:  cur_byte = crc_reg[7:0];
            POS_CRC_HI:  cur_byte = crc_reg[15:8];
            default:     cur_byte = 8'h00;
        endcase
    end

    // running crc; the extra byte folds in right after the quality byte
    always_comb
    begin
        crc_step = crc_fold(crc_reg, cur_byte);
        crc_next = crc_reg;
        if (load)
        begin
            if (pos_reg == POS_START)
            begin
                crc_next = CRC_SEED;
            end
            else if (pos_reg == POS_QUALITY)
            begin
                crc_next = crc_fold(crc_step, cfg.crc_extra);
            end
            else if (pos_reg < POS_QUALITY)
            begin
                crc_next = crc_step;
            end
        end
    end

    // output register and position counter
    always_comb
    begin
        pos_next   = pos_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        if (load)
        begin
            valid_next           = 1'b1;
            data_next.frame_byte = cur_byte;
            data_next.last       = (pos_reg == POS_LAST);
            data_next.led_on     = head_job.led;
            pos_next             = (pos_reg == POS_LAST) ? POS_START : pos_reg + 6'd1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= POS_START;
            crc_reg   <= CRC_SEED;
            valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            crc_reg   <= crc_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// ===== src/mavlink_v1_flow_framer_unit.sv =====
// top level of the optical flow frame builder: config registers and wiring
// depends on mvfl_pkg, mvfl_front, mvfl_queue and mvfl_back
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------
//  in      | in_valid / in_ready  | in_item: flow_x, flow_y, quality
//  out     | out_valid / out_ready| out_item: frame_byte, last, led_on
//  cfg     | cfg_valid / cfg_ready| cfg_index (3 bit), cfg_data (8 bit)
//
// each item yields 34 bytes through the single byte output register, one per
// cycle while out_ready stays high
// up to QUEUE_DEPTH jobs wait between front and back; the next item is taken
// while the current frame still streams
// reset loads the register defaults and clears sequence and led counters
// an out stall holds the current byte; the queue absorbs input meanwhile
module mavlink_v1_flow_framer_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mvfl_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output mvfl_pkg::out_item_t out_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [7:0]          cfg_data
);
    import mvfl_pkg::*;

    cfg_regs_t   cfg_reg, cfg_next;
    frame_job_t  push_job;
    frame_job_t  head_job;
    queue_stat_t q_stat;
    logic        push;
    logic        pop;

    assign cfg_ready = 1'b1;

    // register writes; indexes past the list are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SYSTEM_ID:     cfg_next.system_id     = cfg_data;
                CFG_COMPONENT_ID:  cfg_next.component_id  = cfg_data;
                CFG_MESSAGE_ID:    cfg_next.message_id    = cfg_data;
                CFG_CRC_EXTRA:     cfg_next.crc_extra     = cfg_data;
                CFG_SENSOR_NUMBER: cfg_next.sensor_number = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.system_id     <= SYSTEM_ID_RST;
            cfg_reg.component_id  <= COMPONENT_ID_RST;
            cfg_reg.message_id    <= MESSAGE_ID_RST;
            cfg_reg.crc_extra     <= CRC_EXTRA_RST;
            cfg_reg.sensor_number <= SENSOR_NUMBER_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    mvfl_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .q_stat   (q_stat),
        .push     (push),
        .push_job (push_job)
    );

    mvfl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .q_stat   (q_stat)
    );

    mvfl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_job  (head_job),
        .q_stat    (q_stat),
        .cfg       (cfg_reg),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // a taken byte that is not the last is followed at once by the next one
    // of the same frame, with the same led level
    a_frame_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_item.last |=>
            out_valid && (out_item.led_on == $past(out_item.led_on)))
        else $error("frame bytes not contiguous or led level changed mid frame");

    // an accepted item leaves a job waiting in the queue
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !q_stat.empty)
        else $error("accepted item did not reach the queue");

    // the back end only pops a job that exists, and only on the last byte
    a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty ##1 (out_valid && out_item.last))
        else $error("job popped without a matching last byte");

endmodule
